/* hw/rtl/scfbc_pkg.sv */
package scfbc_pkg;

    // Fixed field widths of the request and result channels
    localparam int PORT_PTR_W = 64;
    localparam int SIZE_W     = 32;
    localparam int LIMIT_W    = 32;
    localparam int CMD_W      = 2;

    // Configuration registers
    localparam int LIMIT_REGS = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [LIMIT_REGS] = '{
        32'd32, 32'd64, 32'd128, 32'd256
    };

    // Classes beyond the register file use BASE_LIMIT shifted by the class number
    localparam logic [LIMIT_W-1:0] BASE_LIMIT = 32'd32;

    // Wide enough for the largest supported class count
    localparam int CLS_IDX_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_POP        = 2'd0,
        CMD_PUSH_SIZED = 2'd1,
        CMD_PUSH_ANY   = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [CLS_IDX_W-1:0] cls;
    } sel_t;

endpackage

/* hw/rtl/scfbc_class_select.sv */
module scfbc_class_select #(
    parameter int CLASS_COUNT     = 4,
    parameter int SLOTS_PER_CLASS = 8,
    parameter int FILL_W          = 4
) (
    input  scfbc_pkg::cmd_t                  cmd,
    input  logic [scfbc_pkg::SIZE_W-1:0]     size,
    input  logic [scfbc_pkg::LIMIT_W-1:0]    limit [CLASS_COUNT],
    input  logic [FILL_W-1:0]                fill  [CLASS_COUNT],
    output scfbc_pkg::sel_t                  sel
);
    import scfbc_pkg::*;

    logic [CLASS_COUNT-1:0] full;
    logic [CLASS_COUNT-1:0] empty;
    logic [CLASS_COUNT-1:0] fits;

    always_comb begin
        for (int i = 0; i < CLASS_COUNT; i++) begin
            full[i]  = (fill[i] == FILL_W'(SLOTS_PER_CLASS));
            empty[i] = (fill[i] == '0);
            fits[i]  = (size <= limit[i]);
        end
    end

    // Four-way (up to eight) priority choice, smallest class first
    always_comb begin
        logic found;
        found = 1'b0;
        sel   = '0;
        unique case (cmd)
            CMD_POP: begin
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    if (!found && !empty[i]) begin
                        found     = 1'b1;
                        sel.rd_en = 1'b1;
                        sel.cls   = CLS_IDX_W'(i);
                    end
                end
            end
            CMD_PUSH_SIZED: begin
                // the first class that fits decides, even when it is full
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    if (!found && fits[i]) begin
                        found     = 1'b1;
                        sel.wr_en = !full[i];
                        sel.cls   = CLS_IDX_W'(i);
                    end
                end
            end
            CMD_PUSH_ANY: begin
                for (int i = 0; i < CLASS_COUNT; i++) begin
                    if (!found && !full[i]) begin
                        found     = 1'b1;
                        sel.wr_en = 1'b1;
                        sel.cls   = CLS_IDX_W'(i);
                    end
                end
            end
            default: begin
                sel = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/scfbc_slot_ram.sv */
module scfbc_slot_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/size_class_free_block_cache.sv */
// Push, failed pop and unused command: result registered in the cycle after the request is accepted,
// one request per cycle while the result channel takes results. Successful pop: the slot memory read
// is registered first, then the result register is loaded from it in ST_POP; the request port stalls in ST_POP.
// Reset (aresetn low, synchronous) empties every class, restores the class limits
// and drops any pending result; slot memory contents are not cleared.
module size_class_free_block_cache #(
    parameter int SLOTS_PER_CLASS = 8,
    parameter int CLASS_COUNT     = 4,
    parameter int POINTER_BITS    = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [63:0] block_pointer, [95:64] request_size
    input  logic [scfbc_pkg::PORT_PTR_W+scfbc_pkg::SIZE_W-1:0] s_tdata,
    // [1:0] command
    input  logic [scfbc_pkg::CMD_W-1:0]           s_tuser,
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [63:0] popped_pointer
    output logic [scfbc_pkg::PORT_PTR_W-1:0]      m_tdata,
    // [0] success
    output logic                                  m_tuser,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [scfbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scfbc_pkg::LIMIT_W-1:0]         cfg_wr_data
);
    import scfbc_pkg::*;

    localparam int FILL_W  = $clog2(SLOTS_PER_CLASS + 1);
    localparam int DEPTH   = CLASS_COUNT * SLOTS_PER_CLASS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W   = POINTER_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0]    limit_reg [LIMIT_REGS];
    logic [LIMIT_W-1:0]    limit     [CLASS_COUNT];
    logic [FILL_W-1:0]     fill_reg  [CLASS_COUNT];

    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg,    out_ok_next;
    logic [PORT_PTR_W-1:0] out_ptr_reg,   out_ptr_next;

    cmd_t                  cmd;
    sel_t                  sel;
    logic                  accept;
    logic [FILL_W-1:0]     sel_fill;
    logic [FILL_W-1:0]     slot;
    logic [ADDR_W-1:0]     addr;
    logic [PTR_W-1:0]      rd_data;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Class limits: registers for the low classes, fixed doubling limits above them
    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_limit
        if (g < LIMIT_REGS) begin : g_reg
            assign limit[g] = limit_reg[g];
        end else begin : g_fixed
            assign limit[g] = BASE_LIMIT << g;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg[cfg_index] <= cfg_wr_data;
        end
    end

    scfbc_class_select #(
        .CLASS_COUNT     (CLASS_COUNT),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .FILL_W          (FILL_W)
    ) u_select (
        .cmd   (cmd),
        .size  (s_tdata[PORT_PTR_W +: SIZE_W]),
        .limit (limit),
        .fill  (fill_reg),
        .sel   (sel)
    );

    // Fill count of the chosen class; a push writes at the count, a pop reads below it
    always_comb begin
        sel_fill = '0;
        for (int i = 0; i < CLASS_COUNT; i++) begin
            if (sel.cls == CLS_IDX_W'(i)) begin
                sel_fill = fill_reg[i];
            end
        end
        slot = sel.wr_en ? sel_fill : sel_fill - FILL_W'(1);
        addr = ADDR_W'(32'(sel.cls) * SLOTS_PER_CLASS + 32'(slot));
    end

    scfbc_slot_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PTR_W)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (accept && sel.wr_en),
        .wr_addr (addr),
        .wr_data (s_tdata[PTR_W-1:0]),
        .rd_en   (accept && sel.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Advance the fill count of the chosen class on every accepted push or pop that succeeds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                if (sel.cls == CLS_IDX_W'(i)) begin
                    if (sel.wr_en) begin
                        fill_reg[i] <= fill_reg[i] + FILL_W'(1);
                    end else if (sel.rd_en) begin
                        fill_reg[i] <= fill_reg[i] - FILL_W'(1);
                    end
                end
            end
        end
    end

    // Result register: loaded at accept, or from the slot read in the cycle after accept for a pop that hit
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_ptr_next   = out_ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sel.rd_en) begin
                        // hold the result until the slot read returns
                        state_next = ST_POP;
                    end else begin
                        out_valid_next = 1'b1;
                        out_ok_next    = sel.wr_en;
                        out_ptr_next   = '0;
                    end
                end
            end
            ST_POP: begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_ok_next    = 1'b1;
                out_ptr_next   = PORT_PTR_W'(rd_data);
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg  <= out_ok_next;
        out_ptr_reg <= out_ptr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = out_ptr_reg;

endmodule

/* hw/rtl/scfbc_checker.sv */
module scfbc_checker (
    input logic                                            aclk,
    input logic                                            aresetn,
    input logic                                            s_tvalid,
    input logic                                            s_tready,
    input logic [scfbc_pkg::CMD_W-1:0]                     s_tuser,
    input logic                                            m_tvalid,
    input logic                                            m_tready,
    input logic [scfbc_pkg::PORT_PTR_W-1:0]                m_tdata,
    input logic                                            m_tuser
);
    import scfbc_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // Drop any pending result on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A failed command never carries a pointer
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed result carries a pointer");

    // Pushes answer in the next cycle with a zero pointer, unused codes with a failure
    a_push_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == CMD_PUSH_SIZED || s_tuser == CMD_PUSH_ANY)
        |=> m_tvalid && m_tdata == '0)
        else $error("push result missing or nonzero pointer");

    a_unused_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == CMD_UNUSED |=> m_tvalid && !m_tuser)
        else $error("unused command did not fail at once");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind size_class_free_block_cache scfbc_checker u_scfbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
